// File: design/fbsg_pkg.sv
// ----------------------------------------------------------------------------
// fbsg_pkg
// Types, field offsets and codes shared by the boot sector geometry block.
// ----------------------------------------------------------------------------
package fbsg_pkg;

  localparam int unsigned OffW   = 6;
  localparam int unsigned DivW   = 32;   // dividend and quotient width
  localparam int unsigned DvsrW  = 16;   // divisor width
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  localparam logic [OffW-1:0] OffMax = '1;

  // Byte offsets of the parameter fields in the boot sector
  localparam logic [OffW-1:0] OffBpsLo   = 6'h0B;
  localparam logic [OffW-1:0] OffBpsHi   = 6'h0C;
  localparam logic [OffW-1:0] OffSpc     = 6'h0D;
  localparam logic [OffW-1:0] OffResLo   = 6'h0E;
  localparam logic [OffW-1:0] OffResHi   = 6'h0F;
  localparam logic [OffW-1:0] OffCopies  = 6'h10;
  localparam logic [OffW-1:0] OffRootLo  = 6'h11;
  localparam logic [OffW-1:0] OffRootHi  = 6'h12;
  localparam logic [OffW-1:0] OffShortLo = 6'h13;
  localparam logic [OffW-1:0] OffShortHi = 6'h14;
  localparam logic [OffW-1:0] OffSpfLo   = 6'h16;
  localparam logic [OffW-1:0] OffSpfHi   = 6'h17;
  localparam logic [OffW-1:0] OffLong0   = 6'h20;
  localparam logic [OffW-1:0] OffLong1   = 6'h21;
  localparam logic [OffW-1:0] OffLong2   = 6'h22;
  localparam logic [OffW-1:0] OffLong3   = 6'h23;
  localparam logic [OffW-1:0] OffLast    = 6'h23;

  localparam logic [15:0] MaxSectorReset  = 16'd8192;
  localparam logic [31:0] MaxClustReset   = 32'd32767;
  localparam logic [31:0] Fat12LimitReset = 32'd4078;

  typedef enum logic [1:0] {
    CFG_MAX_SECTOR  = 2'd0,
    CFG_MAX_CLUST   = 2'd1,
    CFG_FAT12_LIMIT = 2'd2
  } fbsg_cfg_e;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_ZERO_CLUSTER = 3'd1,
    STAT_ZERO_SECTOR  = 3'd2,
    STAT_SECTOR_LARGE = 3'd3,
    STAT_TOO_MANY     = 3'd4
  } fbsg_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ROOT,
    S_SUM,
    S_DIFF,
    S_CLUS,
    S_LOAD
  } fbsg_state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [23:0] cluster_bytes;
    logic [20:0] root_dir_sectors;
    logic [15:0] fat_sectors;
    logic [16:0] second_fat_start;
    logic [24:0] data_start;
    logic [31:0] cluster_count;
    logic        is_fat16;
  } fbsg_out_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic check_en;
    logic div_start;
    logic div_sel_clus;  // 0: root directory length, 1: cluster count
    logic sum_en;
    logic diff_en;
    logic load;
  } fbsg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_fire;
    logic early_fail;
    logic below_data;
    logic div_busy;
    logic div_done;
    logic out_free;
  } fbsg_sts_t;

endpackage

// File: design/fbsg_if.sv
// ----------------------------------------------------------------------------
// fbsg_if
// Request channels of the boot sector geometry block: sector bytes in,
// geometry out, register writes.
// ----------------------------------------------------------------------------
interface fbsg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sector_start;

  modport source (output valid, data_byte, sector_start, input ready);
  modport sink   (input valid, data_byte, sector_start, output ready);
endinterface

interface fbsg_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] sector_bytes;
  logic [7:0]  cluster_sectors;
  logic [23:0] cluster_bytes;
  logic [20:0] root_dir_sectors;
  logic [15:0] fat_sectors;
  logic [16:0] second_fat_start;
  logic [24:0] data_start;
  logic [31:0] cluster_count;
  logic        is_fat16;

  modport source (output valid, status, sector_bytes, cluster_sectors, cluster_bytes,
                  root_dir_sectors, fat_sectors, second_fat_start, data_start,
                  cluster_count, is_fat16, input ready);
  modport sink   (input valid, status, sector_bytes, cluster_sectors, cluster_bytes,
                  root_dir_sectors, fat_sectors, second_fat_start, data_start,
                  cluster_count, is_fat16, output ready);
endinterface

interface fbsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_idx;
  logic [31:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// File: design/fbsg_div.sv
// ----------------------------------------------------------------------------
// fbsg_div
// Restoring divider, one quotient bit per cycle. Shared by the root directory
// length and the cluster count.
// ----------------------------------------------------------------------------
module fbsg_div import fbsg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [DvsrW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DivW-1:0]  quotient_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsrW-1:0]   rem_q, rem_d;
  logic [DvsrW-1:0]   dvsr_q, dvsr_d;
  logic [DvsrW:0]     rem_sh;
  logic [DvsrW:0]     rem_sub;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      cnt_d  = DivCntW'(DivW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= {1'b0, dvsr_q}) begin
        // remainder stays below the divisor, so the top bit drops out
        rem_d = rem_sub[DvsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DvsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign done_o     = (cnt_q == DivCntW'(1));
  assign quotient_o = quo_q;

endmodule

// File: design/fbsg_dp.sv
// ----------------------------------------------------------------------------
// fbsg_dp
// Datapath: byte offset and field capture, registers, geometry arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module fbsg_dp import fbsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fbsg_cmd_t   cmd_i,
  output fbsg_sts_t   sts_o,
  input  logic        in_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        sector_start_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output fbsg_out_t   out_o
);

  logic [OffW-1:0] off_q, off_eff;
  logic            in_fire;

  logic [15:0] max_sector_q;
  logic [31:0] max_clust_q;
  logic [31:0] fat12_limit_q;

  logic [7:0]  spc_q, copies_q;
  logic [15:0] bps_q, root_q, res_raw_q, spf_q, short_q;
  logic [31:0] long_q;

  logic [23:0] prod_q, cb_q;
  logic [20:0] rdlen_q;
  logic [24:0] datrec_q;
  logic [2:0]  stat_q;

  logic [15:0] res;
  logic [31:0] total;
  logic [2:0]  early_code;
  logic [21:0] root_num;
  logic [DivW-1:0]  div_dividend;
  logic [DvsrW-1:0] div_divisor;
  logic             div_busy, div_done;
  logic [DivW-1:0]  quo;

  logic        out_valid_q;
  fbsg_out_t   out_q, out_d;
  logic [2:0]  final_stat;
  logic        geo_ok, all_ok;

  assign in_fire = in_valid_i & cmd_i.in_ready;
  assign off_eff = sector_start_i ? '0 : off_q;

  // Byte offset, saturating at the top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (in_fire) begin
      off_q <= (off_eff == OffMax) ? OffMax : off_eff + 1'b1;
    end
  end

  // Field capture, little-endian
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      case (off_eff)
        OffBpsLo:   bps_q[7:0]      <= data_byte_i;
        OffBpsHi:   bps_q[15:8]     <= data_byte_i;
        OffSpc:     spc_q           <= data_byte_i;
        OffResLo:   res_raw_q[7:0]  <= data_byte_i;
        OffResHi:   res_raw_q[15:8] <= data_byte_i;
        OffCopies:  copies_q        <= data_byte_i;
        OffRootLo:  root_q[7:0]     <= data_byte_i;
        OffRootHi:  root_q[15:8]    <= data_byte_i;
        OffShortLo: short_q[7:0]    <= data_byte_i;
        OffShortHi: short_q[15:8]   <= data_byte_i;
        OffSpfLo:   spf_q[7:0]      <= data_byte_i;
        OffSpfHi:   spf_q[15:8]     <= data_byte_i;
        OffLong0:   long_q[7:0]     <= data_byte_i;
        OffLong1:   long_q[15:8]    <= data_byte_i;
        OffLong2:   long_q[23:16]   <= data_byte_i;
        OffLong3:   long_q[31:24]   <= data_byte_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sector_q  <= MaxSectorReset;
      max_clust_q   <= MaxClustReset;
      fat12_limit_q <= Fat12LimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_MAX_SECTOR:  max_sector_q  <= cfg_wdata_i[15:0];
        CFG_MAX_CLUST:   max_clust_q   <= cfg_wdata_i;
        CFG_FAT12_LIMIT: fat12_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign res   = (res_raw_q == '0) ? 16'd1 : res_raw_q;
  assign total = (short_q == '0) ? long_q : {16'b0, short_q};

  always_comb begin
    if (spc_q == '0) begin
      early_code = STAT_ZERO_CLUSTER;
    end else if (bps_q == '0) begin
      early_code = STAT_ZERO_SECTOR;
    end else if (bps_q > max_sector_q) begin
      early_code = STAT_SECTOR_LARGE;
    end else begin
      early_code = STAT_OK;
    end
  end

  // 32 bytes per root entry, rounded up; bps is non-zero here
  assign root_num = {1'b0, root_q, 5'b0} + {6'b0, bps_q} - 22'd1;

  assign div_dividend = cmd_i.div_sel_clus ? (total - {7'b0, datrec_q})
                                           : {10'b0, root_num};
  assign div_divisor  = cmd_i.div_sel_clus ? {8'b0, spc_q} : bps_q;

  fbsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Products are registered before any sum uses them
  always_ff @(posedge clk_i) begin
    prod_q <= {16'b0, copies_q} * {8'b0, spf_q};
    cb_q   <= {16'b0, spc_q} * {8'b0, bps_q};
    if (cmd_i.sum_en) begin
      rdlen_q  <= quo[20:0];
      datrec_q <= {9'b0, res} + {1'b0, prod_q} + {3'b0, quo[21:0]};
    end
    if (cmd_i.check_en) begin
      stat_q <= early_code;
    end else if (cmd_i.diff_en && sts_o.below_data) begin
      stat_q <= STAT_TOO_MANY;
    end
  end

  assign final_stat = (stat_q == STAT_OK && quo > max_clust_q) ? STAT_TOO_MANY : stat_q;
  assign all_ok     = (final_stat == STAT_OK);
  assign geo_ok     = all_ok || (final_stat == STAT_TOO_MANY);

  always_comb begin
    out_d                  = '0;
    out_d.status           = final_stat;
    if (geo_ok) begin
      out_d.cluster_sectors  = spc_q;
      out_d.cluster_bytes    = cb_q;
      out_d.root_dir_sectors = rdlen_q;
      out_d.fat_sectors      = spf_q;
      out_d.second_fat_start = {1'b0, res} + {1'b0, spf_q};
      out_d.data_start       = datrec_q;
    end
    if (all_ok) begin
      out_d.sector_bytes  = bps_q;
      out_d.cluster_count = quo;
      out_d.is_fat16      = (quo > fat12_limit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sts_o.last_fire  = in_fire && (off_eff == OffLast);
  assign sts_o.early_fail = (early_code != STAT_OK);
  assign sts_o.below_data = (total < {7'b0, datrec_q});
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STAT_OK) |-> (out_q.cluster_count <= max_clust_q))
    else $error("ok result with cluster count above limit");

endmodule

// File: design/fbsg_ctrl.sv
// ----------------------------------------------------------------------------
// fbsg_ctrl
// Sequencer: takes bytes while idle, then steps through the checks and, as far
// as the checks allow, the two divisions and hands the result to the output register.
// ----------------------------------------------------------------------------
module fbsg_ctrl import fbsg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fbsg_sts_t sts_i,
  output fbsg_cmd_t cmd_o
);

  fbsg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (sts_i.last_fire) state_d = S_CHECK;
      S_CHECK: state_d = sts_i.early_fail ? S_LOAD : S_ROOT;
      S_ROOT:  if (sts_i.div_done) state_d = S_SUM;
      S_SUM:   state_d = S_DIFF;
      S_DIFF:  state_d = sts_i.below_data ? S_LOAD : S_CLUS;
      S_CLUS:  if (sts_i.div_done) state_d = S_LOAD;
      S_LOAD:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.in_ready = 1'b1;
      S_CHECK: begin
        cmd_o.check_en  = 1'b1;
        cmd_o.div_start = !sts_i.early_fail;
      end
      S_SUM: cmd_o.sum_en = 1'b1;
      S_DIFF: begin
        cmd_o.diff_en      = 1'b1;
        cmd_o.div_sel_clus = 1'b1;
        cmd_o.div_start    = !sts_i.below_data;
      end
      S_CLUS: cmd_o.div_sel_clus = 1'b1;
      S_LOAD: cmd_o.load = sts_i.out_free;
      default: ;
    endcase
  end

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT || state_q == S_CLUS) |-> sts_i.div_busy)
    else $error("waiting on a divider that is not running");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_ready |-> !sts_i.div_busy)
    else $error("bytes taken while a division is in flight");

endmodule

// File: design/fat_boot_sector_geometry.sv
// ----------------------------------------------------------------------------
// fat_boot_sector_geometry
// FAT12/FAT16 boot sector parser: captures the parameter fields and gives
// the volume geometry once per sector.
// ----------------------------------------------------------------------------
// Bytes of a boot sector are taken one per cycle while the block is idle.
// The byte at offset 0x23 starts the geometry calculation, and the byte
// input then stays stalled through a check step, the root directory length
// division, a summing step, a difference step, the cluster count division
// and the result load; a failed cluster size or sector size check goes
// straight to the load, and a total sector count below the data start skips
// the cluster count division. Both divisions run on one shared divider that
// yields one quotient bit a cycle. A waiting result does not stall the byte
// input; a following calculation waits only if the previous result is still
// untaken when it finishes. Register writes are taken in any cycle.
module fat_boot_sector_geometry import fbsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbsg_in_if.sink     in_i,
  fbsg_out_if.source  res_o,
  fbsg_cfg_if.sink    cfg_i
);

  fbsg_cmd_t cmd;
  fbsg_sts_t sts;
  fbsg_out_t out;
  logic      out_valid;

  fbsg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fbsg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_i     (in_i.valid),
    .data_byte_i    (in_i.data_byte),
    .sector_start_i (in_i.sector_start),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_idx_i      (cfg_i.reg_idx),
    .cfg_wdata_i    (cfg_i.wdata),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (out_valid),
    .out_o          (out)
  );

  assign in_i.ready  = cmd.in_ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid            = out_valid;
  assign res_o.status           = out.status;
  assign res_o.sector_bytes     = out.sector_bytes;
  assign res_o.cluster_sectors  = out.cluster_sectors;
  assign res_o.cluster_bytes    = out.cluster_bytes;
  assign res_o.root_dir_sectors = out.root_dir_sectors;
  assign res_o.fat_sectors      = out.fat_sectors;
  assign res_o.second_fat_start = out.second_fat_start;
  assign res_o.data_start       = out.data_start;
  assign res_o.cluster_count    = out.cluster_count;
  assign res_o.is_fat16         = out.is_fat16;

endmodule
